// ===== hw/rtl/bbd_pkg.sv =====
// Shared types, constants and color-site helpers for the Bayer demosaic block.
`timescale 1ns / 1ps
package bbd_pkg;

    localparam int PIX_W      = 8;
    localparam int PHASE_W    = 2;
    localparam int FW_W       = 13;
    localparam int FH_W       = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    localparam int FRAME_WIDTH_RST  = 4096;
    localparam int FRAME_HEIGHT_RST = 3072;

    localparam logic [CFG_IDX_W-1:0] REG_CFA_PHASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_RGGB = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_BGGR = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_GBRG = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_GRBG = 2'd3;

    typedef enum logic [1:0] {
        SITE_R,
        SITE_G,
        SITE_B
    } site_t;

    typedef logic [PIX_W-1:0] pix_t;
    // One window column, rows top to bottom.
    typedef pix_t [2:0] col_t;
    // Index 0 is the older column, index 1 the center column.
    typedef col_t [1:0] win_t;

    typedef struct packed {
        logic  left;
        logic  right;
        logic  top;
        logic  bottom;
        site_t site;
        logic  red_row;
    } interp_ctl_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic end_of_row;
        logic end_of_frame;
    } result_t;

    function automatic site_t site_colour(logic [PHASE_W-1:0] phase, logic x_odd,
                                          logic y_odd);
        site_t s;
        case (phase)
            PHASE_BGGR: s = !y_odd ? (!x_odd ? SITE_B : SITE_G) : (!x_odd ? SITE_G : SITE_R);
            PHASE_GBRG: s = !y_odd ? (!x_odd ? SITE_G : SITE_B) : (!x_odd ? SITE_R : SITE_G);
            PHASE_GRBG: s = !y_odd ? (!x_odd ? SITE_G : SITE_R) : (!x_odd ? SITE_B : SITE_G);
            default:    s = !y_odd ? (!x_odd ? SITE_R : SITE_G) : (!x_odd ? SITE_G : SITE_B);
        endcase
        return s;
    endfunction

    // True when the row holding the site carries red samples.
    function automatic logic red_row(logic [PHASE_W-1:0] phase, logic y_odd);
        logic odd_red;
        odd_red = (phase == PHASE_BGGR) || (phase == PHASE_GBRG);
        return odd_red ? y_odd : !y_odd;
    endfunction

endpackage

// ===== hw/rtl/bbd_if.sv =====
// Stream interfaces for Bayer samples in and RGB pixels out.
`timescale 1ns / 1ps
interface bbd_in_if;
    import bbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] raw_pixel;
    logic             drain;

    modport source (output valid, raw_pixel, drain, input ready);
    modport sink (input valid, raw_pixel, drain, output ready);
endinterface

interface bbd_out_if;
    import bbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             end_of_row;
    logic             end_of_frame;

    modport source (output valid, red, green, blue, end_of_row, end_of_frame, input ready);
    modport sink (input valid, red, green, blue, end_of_row, end_of_frame, output ready);
endinterface

// ===== hw/rtl/bbd_line_store.sv =====
// Two line memories sharing one address, with forwarding of a same-address write.
`timescale 1ns / 1ps
module bbd_line_store #(
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  bbd_pkg::pix_t              wr_upper,
    input  bbd_pkg::pix_t              wr_middle,
    output bbd_pkg::pix_t              upper_q,
    output bbd_pkg::pix_t              middle_q
);
    import bbd_pkg::*;

    pix_t upper_mem  [DEPTH];
    pix_t middle_mem [DEPTH];
    pix_t rd_upper_reg;
    pix_t rd_middle_reg;
    pix_t fwd_upper_reg;
    pix_t fwd_middle_reg;
    logic fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            rd_upper_reg   <= upper_mem[rd_addr];
            rd_middle_reg  <= middle_mem[rd_addr];
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    // A read in the same cycle as a write to its entry sees the old data,
    // so the written values are kept and substituted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign upper_q  = fwd_reg ? fwd_upper_reg  : rd_upper_reg;
    assign middle_q = fwd_reg ? fwd_middle_reg : rd_middle_reg;

endmodule

// ===== hw/rtl/bbd_interp.sv =====
// Bilinear interpolation of one site from the 3x3 window with edge clamping.
`timescale 1ns / 1ps
module bbd_interp (
    input  bbd_pkg::win_t        win,
    input  bbd_pkg::col_t        newest,
    input  bbd_pkg::interp_ctl_t ctl,
    output bbd_pkg::pix_t        red,
    output bbd_pkg::pix_t        green,
    output bbd_pkg::pix_t        blue
);
    import bbd_pkg::*;

    col_t       c;
    col_t       lc;
    col_t       rc;
    pix_t       l, r, u, d, ul, ur, dl, dr;
    logic [9:0] edge_sum;
    logic [9:0] diag_sum;
    logic [8:0] h_sum;
    logic [8:0] v_sum;

    always_comb
    begin
        c  = win[1];
        lc = ctl.left  ? c : win[0];
        rc = ctl.right ? c : newest;
        l  = lc[1];
        r  = rc[1];
        u  = ctl.top    ? c[1]  : c[0];
        d  = ctl.bottom ? c[1]  : c[2];
        ul = ctl.top    ? lc[1] : lc[0];
        ur = ctl.top    ? rc[1] : rc[0];
        dl = ctl.bottom ? lc[1] : lc[2];
        dr = ctl.bottom ? rc[1] : rc[2];

        edge_sum = 10'(l) + 10'(r) + 10'(u) + 10'(d);
        diag_sum = 10'(ul) + 10'(ur) + 10'(dl) + 10'(dr);
        h_sum    = 9'(l) + 9'(r);
        v_sum    = 9'(u) + 9'(d);

        case (ctl.site)
            SITE_R:
            begin
                red   = c[1];
                green = edge_sum[9:2];
                blue  = diag_sum[9:2];
            end
            SITE_B:
            begin
                red   = diag_sum[9:2];
                green = edge_sum[9:2];
                blue  = c[1];
            end
            default:
            begin
                green = c[1];
                red   = ctl.red_row ? h_sum[8:1] : v_sum[8:1];
                blue  = ctl.red_row ? v_sum[8:1] : h_sum[8:1];
            end
        endcase
    end

endmodule

// ===== hw/rtl/bbd_out_buf.sv =====
// Two-entry output buffer that decouples the result stream from the input side.
`timescale 1ns / 1ps
module bbd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bbd_pkg::result_t  push_data,
    output logic              space,
    bbd_out_if.source         pixel_out
);
    import bbd_pkg::*;

    result_t    entry_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic       pop;
    result_t    head_data;

    assign pop   = pixel_out.valid && pixel_out.ready;
    assign space = (count_reg != 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= !tail_reg;
            end
            if (pop)
            begin
                head_reg <= !head_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head_data              = entry_reg[head_reg];
    assign pixel_out.valid        = (count_reg != 2'd0);
    assign pixel_out.red          = head_data.red;
    assign pixel_out.green        = head_data.green;
    assign pixel_out.blue         = head_data.blue;
    assign pixel_out.end_of_row   = head_data.end_of_row;
    assign pixel_out.end_of_frame = head_data.end_of_frame;

endmodule

// ===== hw/rtl/bilinear_bayer_demosaic_core.sv =====
// Top level of the streaming 3x3 bilinear Bayer demosaic.
`timescale 1ns / 1ps
// Usage:
// Bayer samples enter on pixel_in in raster order, one per transfer; RGB
// pixels leave on pixel_out, one per frame site, with end_of_row and
// end_of_frame marks. The pixel at (x, y) is produced by the transfer of the
// sample one row plus one pixel after it in raster order. After the last sample
// of a frame, frame_width + 1 drain items (drain = 1) release the remaining
// pixels; drains sent earlier are dropped. Throughput is one item per clock
// while the output buffer has space: the two line memories are read when an
// item is taken and written back as it leaves the working stage, a single
// read-modify-write per frame sample. Results reach pixel_out through a
// registered two-entry output buffer that absorbs receiver stalls; pixel_in
// is held off only once it is full and the working stage is occupied. Reset
// clears the position counters and the window and loads cfa_phase = 1,
// frame_width = 4096 and frame_height = 3072. The line memories are not
// cleared; stale entries reach only window rows that edge clamping replaces.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) belong in idle time.
module bilinear_bayer_demosaic_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 16383
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    bbd_in_if.sink                            pixel_in,
    bbd_out_if.source                         pixel_out
);
    import bbd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ORW    = $clog2(MAX_HEIGHT);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST  = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    // Configuration, stored as clamped geometry minus one.
    logic [PHASE_W-1:0] phase_reg;
    logic [COL_W-1:0]   wm1_reg;
    logic [COL_W-1:0]   wm1_next;
    logic [ORW-1:0]     hm1_reg;
    logic [ORW-1:0]     hm1_next;
    logic [FW_W-1:0]    fw_raw;
    logic [FH_W-1:0]    fh_raw;

    // Working stage.
    logic        s1_valid_reg;
    pix_t        s1_pixel_reg;
    logic        s1_drain_reg;
    logic        s1_fire;
    logic        accept;
    logic        flushing;
    logic        ignore;
    logic        active;
    logic        has_result;
    logic        eor;
    logic        eof;
    logic        push;
    logic        space;

    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [IROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0]    out_row_reg, out_row_next;
    win_t              win_reg, win_next;

    pix_t        upper_q;
    pix_t        middle_q;
    col_t        newest;
    interp_ctl_t ctl;
    result_t     result;

    always_comb
    begin
        fw_raw = cfg_data[FW_W-1:0];
        fh_raw = cfg_data[FH_W-1:0];
        if (fw_raw == '0)
            wm1_next = '0;
        else if (32'(fw_raw) > MAX_WIDTH)
            wm1_next = COL_W'(MAX_WIDTH - 1);
        else
            wm1_next = COL_W'(32'(fw_raw) - 32'd1);
        if (fh_raw == '0)
            hm1_next = '0;
        else if (32'(fh_raw) > MAX_HEIGHT)
            hm1_next = ORW'(MAX_HEIGHT - 1);
        else
            hm1_next = ORW'(32'(fh_raw) - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_BGGR;
            wm1_reg   <= COL_W'(W_RST - 1);
            hm1_reg   <= ORW'(H_RST - 1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_CFA_PHASE:    phase_reg <= cfg_data[PHASE_W-1:0];
                REG_FRAME_WIDTH:  wm1_reg   <= wm1_next;
                REG_FRAME_HEIGHT: hm1_reg   <= hm1_next;
                default:          ;
            endcase
        end
    end

    assign s1_fire        = s1_valid_reg && space;
    assign pixel_in.ready = !s1_valid_reg || s1_fire;
    assign accept         = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        flushing   = in_row_reg > IROW_W'(hm1_reg);
        ignore     = s1_drain_reg && !flushing;
        active     = s1_fire && !ignore;
        has_result = (in_row_reg != '0) && ((in_col_reg != '0) || (in_row_reg >= IROW_W'(2)));
        eor        = out_col_reg >= wm1_reg;
        eof        = eor && (out_row_reg >= hm1_reg);
        push       = active && has_result;

        newest[0] = upper_q;
        newest[1] = middle_q;
        newest[2] = flushing ? middle_q : s1_pixel_reg;

        ctl.left    = (out_col_reg == '0);
        ctl.right   = eor;
        ctl.top     = (out_row_reg == '0);
        ctl.bottom  = out_row_reg >= hm1_reg;
        ctl.site    = site_colour(phase_reg, out_col_reg[0], out_row_reg[0]);
        ctl.red_row = red_row(phase_reg, out_row_reg[0]);

        win_next     = win_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (active)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = newest;
            if (in_col_reg >= wm1_reg)
            begin
                in_col_next = '0;
                // The input row saturates at frame_height + 1 while the flush runs.
                if (in_row_reg <= IROW_W'(hm1_reg) + IROW_W'(1))
                    in_row_next = in_row_reg + IROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (has_result)
            begin
                if (eor)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ORW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            if (has_result && eof)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            win_reg      <= '0;
        end
        else
        begin
            if (pixel_in.ready)
                s1_valid_reg <= pixel_in.valid;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel_in.raw_pixel;
            s1_drain_reg <= pixel_in.drain;
        end
    end

    // The next item reads at the column the current item leaves behind.
    bbd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (in_col_next),
        .wr_en     (active && !flushing),
        .wr_addr   (in_col_reg),
        .wr_upper  (middle_q),
        .wr_middle (s1_pixel_reg),
        .upper_q   (upper_q),
        .middle_q  (middle_q)
    );

    bbd_interp u_interp (
        .win    (win_reg),
        .newest (newest),
        .ctl    (ctl),
        .red    (result.red),
        .green  (result.green),
        .blue   (result.blue)
    );

    assign result.end_of_row   = eor;
    assign result.end_of_frame = eof;

    bbd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .space     (space),
        .pixel_out (pixel_out)
    );

    a_push_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed into a full output buffer");

    a_eof_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
        (push && eof) |=> (in_col_reg == '0) && (in_row_reg == '0) &&
                          (out_col_reg == '0) && (out_row_reg == '0))
        else $error("position counters not cleared after end of frame");

    a_early_drain_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && ignore) |=> $stable(in_col_reg) && $stable(in_row_reg) &&
                               $stable(out_col_reg) && $stable(out_row_reg))
        else $error("early drain changed the position");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the Bayer demosaic core with a built-in bilinear predictor.
`timescale 1ns / 1ps
module tb_top;
    import bbd_pkg::*;

    localparam int LINE_DEPTH    = 4096;
    localparam int MAX_ROWS      = 16383;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int QUIET_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 5_000_000;

    typedef struct packed {
        pix_t pix;
        logic drn;
    } bayer_item_t;

    // Rows top to bottom of one window column.
    typedef logic [2:0][PIX_W-1:0] sample_column_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic send_valid = 1'b0;
    pix_t send_pixel = '0;
    logic send_drain = 1'b0;
    logic take_ready = 1'b0;

    bbd_in_if  pixel_in_ch ();
    bbd_out_if pixel_out_ch ();

    assign pixel_in_ch.valid     = send_valid;
    assign pixel_in_ch.raw_pixel = send_pixel;
    assign pixel_in_ch.drain     = send_drain;
    assign pixel_out_ch.ready    = take_ready;

    bilinear_bayer_demosaic_core #(
        .MAX_WIDTH  (LINE_DEPTH),
        .MAX_HEIGHT (MAX_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_in_ch),
        .pixel_out    (pixel_out_ch)
    );

    bayer_item_t pending_samples[$];
    result_t     expected_pixels[$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    int unsigned mismatch_count = 0;
    int unsigned stream_items = 0;
    int unsigned cycle_count = 0;

    // Predictor copy of the configuration and the datapath state.
    logic [PHASE_W-1:0] cur_phase = PHASE_BGGR;
    logic [FW_W-1:0]    cur_width = FW_W'(FRAME_WIDTH_RST);
    logic [FH_W-1:0]    cur_height = FH_W'(FRAME_HEIGHT_RST);
    pix_t               upper_mem [LINE_DEPTH] = '{default: '0};
    pix_t               middle_mem [LINE_DEPTH] = '{default: '0};
    sample_column_t     win_cols [3] = '{default: '0};
    int unsigned        cap_col = 0;
    int unsigned        cap_row = 0;
    int unsigned        emit_col = 0;
    int unsigned        emit_row = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Advances the predictor by one accepted item; returns 1 when a pixel comes out.
    function automatic bit demosaic_step(input pix_t px, input logic drn,
                                         output result_t px_out);
        int unsigned    w, h, slot, ctr, l, r, u, d, ul, ur, dl, dr;
        int unsigned    red_v, grn_v, blu_v;
        int             ti, bi;
        bit             flushing, emit, eor, eof, on_red_row, on_red_col;
        logic [1:0]     red_at;
        sample_column_t fresh, cc, lc, rc;
        site_t          site;

        w = (cur_width == 0) ? 1 : ((cur_width > LINE_DEPTH) ? LINE_DEPTH : cur_width);
        h = (cur_height == 0) ? 1 : ((cur_height > MAX_ROWS) ? MAX_ROWS : cur_height);
        flushing = cap_row >= h;
        px_out = '0;
        eof = 1'b0;
        if (drn && !flushing)
            return 1'b0;

        slot = (cap_col < LINE_DEPTH) ? cap_col : LINE_DEPTH - 1;
        fresh[0] = upper_mem[slot];
        fresh[1] = middle_mem[slot];
        // Below the frame the last row is repeated.
        fresh[2] = flushing ? middle_mem[slot] : px;
        if (!flushing) begin
            upper_mem[slot] = middle_mem[slot];
            middle_mem[slot] = px;
        end

        emit = (cap_row >= 1) && (cap_col >= 1 || cap_row >= 2);
        if (emit) begin
            cc = win_cols[2];
            lc = (emit_col == 0) ? cc : win_cols[1];
            eor = emit_col >= w - 1;
            rc = eor ? cc : fresh;
            ti = (emit_row == 0) ? 1 : 0;
            bi = (emit_row >= h - 1) ? 1 : 2;
            ctr = cc[1];
            l = lc[1];
            r = rc[1];
            u = cc[ti];
            d = cc[bi];
            ul = lc[ti];
            ur = rc[ti];
            dl = lc[bi];
            dr = rc[bi];

            // Position of the red sample inside the 2x2 tile as {row, column}.
            case (cur_phase)
                PHASE_BGGR: red_at = 2'b11;
                PHASE_GBRG: red_at = 2'b10;
                PHASE_GRBG: red_at = 2'b01;
                default:    red_at = 2'b00;
            endcase
            on_red_row = emit_row[0] == red_at[1];
            on_red_col = emit_col[0] == red_at[0];
            if (on_red_row && on_red_col)
                site = SITE_R;
            else if (!on_red_row && !on_red_col)
                site = SITE_B;
            else
                site = SITE_G;

            case (site)
                SITE_R: begin
                    red_v = ctr;
                    grn_v = (l + r + u + d) >> 2;
                    blu_v = (ul + ur + dl + dr) >> 2;
                end
                SITE_B: begin
                    blu_v = ctr;
                    grn_v = (l + r + u + d) >> 2;
                    red_v = (ul + ur + dl + dr) >> 2;
                end
                default: begin
                    grn_v = ctr;
                    if (on_red_row) begin
                        red_v = (l + r) >> 1;
                        blu_v = (u + d) >> 1;
                    end else begin
                        blu_v = (l + r) >> 1;
                        red_v = (u + d) >> 1;
                    end
                end
            endcase

            eof = eor && (emit_row >= h - 1);
            px_out.red = red_v[7:0];
            px_out.green = grn_v[7:0];
            px_out.blue = blu_v[7:0];
            px_out.end_of_row = eor;
            px_out.end_of_frame = eof;
            if (eor) begin
                emit_col = 0;
                emit_row++;
            end else begin
                emit_col++;
            end
        end

        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = fresh;

        if (cap_col >= w - 1) begin
            cap_col = 0;
            if (cap_row < h + 1)
                cap_row++;
        end else begin
            cap_col++;
        end

        if (eof) begin
            cap_col = 0;
            cap_row = 0;
            emit_col = 0;
            emit_row = 0;
        end
        return emit;
    endfunction

    function automatic void log_mismatch(input string what, input result_t want,
                                         input result_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected r=%0d g=%0d b=%0d eor=%0b eof=%0b, got r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                     $time, what, want.red, want.green, want.blue, want.end_of_row,
                     want.end_of_frame, seen.red, seen.green, seen.blue, seen.end_of_row,
                     seen.end_of_frame);
    endfunction

    // Sample driver: predicts on every transfer, then offers the next queued item.
    always @(posedge clk or negedge rst_n) begin : drive_samples
        bayer_item_t next_item;
        result_t     predicted;
        if (!rst_n) begin
            send_valid <= 1'b0;
            send_pixel <= '0;
            send_drain <= 1'b0;
            send_gap = 0;
        end else begin
            if (send_valid && pixel_in_ch.ready) begin
                if (demosaic_step(send_pixel, send_drain, predicted))
                    expected_pixels.push_back(predicted);
            end
            if (!send_valid || pixel_in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    send_valid <= 1'b0;
                end else if (pending_samples.size() != 0 && src_idle_pct != 0 &&
                             $urandom_range(0, 99) < src_idle_pct) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    send_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    next_item = pending_samples.pop_front();
                    send_valid <= 1'b1;
                    send_pixel <= next_item.pix;
                    send_drain <= next_item.drn;
                end else begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: checks every output transfer and stalls the output at random.
    always @(posedge clk or negedge rst_n) begin : check_pixels
        result_t seen;
        result_t want;
        if (!rst_n) begin
            take_ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (pixel_out_ch.valid && take_ready) begin
                seen.red = pixel_out_ch.red;
                seen.green = pixel_out_ch.green;
                seen.blue = pixel_out_ch.blue;
                seen.end_of_row = pixel_out_ch.end_of_row;
                seen.end_of_frame = pixel_out_ch.end_of_frame;
                if (expected_pixels.size() == 0) begin
                    log_mismatch("pixel with nothing pending", '0, seen);
                end else begin
                    want = expected_pixels.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue || seen.end_of_row !== want.end_of_row ||
                        seen.end_of_frame !== want.end_of_frame)
                        log_mismatch("pixel differs", want, seen);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                take_ready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                take_gap = $urandom_range(1, 14) - 1;
                take_ready <= 1'b0;
            end else begin
                take_ready <= 1'b1;
            end
        end
    end

    function automatic void push_sample(input pix_t px, input logic drn);
        bayer_item_t item;
        item.pix = px;
        item.drn = drn;
        pending_samples.push_back(item);
    endfunction

    function automatic pix_t random_sample();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 12;
        endcase
    endfunction

    // Returns once every queued item is sent and every predicted pixel has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || send_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_CFA_PHASE:    cur_phase = value[PHASE_W-1:0];
            REG_FRAME_WIDTH:  cur_width = value[FW_W-1:0];
            REG_FRAME_HEIGHT: cur_height = value[FH_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic program_block(input logic [CFG_DATA_W-1:0] phase_word,
                                 input logic [CFG_DATA_W-1:0] width_word,
                                 input logic [CFG_DATA_W-1:0] height_word);
        write_reg(REG_CFA_PHASE, phase_word);
        write_reg(REG_FRAME_WIDTH, width_word);
        write_reg(REG_FRAME_HEIGHT, height_word);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Queues one frame of w x h samples and its flush; stray drains are sprinkled in.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned stray_pct, input int unsigned flush_px_pct,
                               input bit pause_mid);
        int unsigned n_pix;
        int unsigned k;
        n_pix = w * h;
        for (k = 0; k < n_pix; k++) begin
            if (pause_mid && k == n_pix / 2)
                wait_idle();
            if ($urandom_range(0, 99) < stray_pct)
                push_sample(random_sample(), 1'b1);
            push_sample(random_sample(), 1'b0);
        end
        // A pixel sent during the flush counts as a drain.
        for (k = 0; k <= w; k++)
            push_sample(random_sample(), $urandom_range(0, 99) >= flush_px_pct);
        stream_items += n_pix + w + 1;
    endtask

    initial begin : run_stimulus
        int unsigned w;
        int unsigned h;
        bit          pause_pending;
        logic [CFG_DATA_W-1:0] phase_word;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        src_idle_pct = 12;
        sink_idle_pct = 12;

        // 3x3 RGGB frame with drains before and inside the frame and a pixel in the flush.
        program_block(CFG_DATA_W'(PHASE_RGGB), 14'd3, 14'd3);
        push_sample(8'h5A, 1'b1);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'hA5, 1'b1);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd0, 1'b1);
        push_sample(8'd77, 1'b0);
        push_sample(8'd255, 1'b1);
        push_sample(8'd0, 1'b1);
        wait_idle();

        // Zero width and height count as one; junk above the phase bits is dropped.
        program_block({12'hFFF, PHASE_BGGR}, 14'd0, 14'd0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b1);
        push_sample(8'd255, 1'b1);
        wait_idle();

        // Width bit above the register is dropped, leaving 2.
        program_block(CFG_DATA_W'(PHASE_GRBG), 14'h2002, 14'd2);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd5, 1'b0);
        push_sample(8'd0, 1'b1);
        push_sample(8'd0, 1'b1);
        wait_idle();

        stream_items = 0;
        pause_pending = 1'b1;
        while (stream_items < RANDOM_ITEMS) begin
            wait_idle();
            if (stream_items + QUIET_ITEMS >= RANDOM_ITEMS) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct = pick_idle_pct();
                sink_idle_pct = pick_idle_pct();
            end
            if ($urandom_range(0, 6) == 0) begin
                w = $urandom_range(13, 48);
                h = $urandom_range(1, 12);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            phase_word = CFG_DATA_W'($urandom_range(0, 16383));
            program_block(phase_word,
                          (w == 1 && $urandom_range(0, 1) == 1) ? 14'd0 : CFG_DATA_W'(w),
                          (h == 1 && $urandom_range(0, 1) == 1) ? 14'd0 : CFG_DATA_W'(h));
            if (w * h >= 4 && (pause_pending || $urandom_range(0, 9) == 0)) begin
                queue_frame(w, h, $urandom_range(0, 10), $urandom_range(0, 40), 1'b1);
                pause_pending = 1'b0;
            end else begin
                queue_frame(w, h, $urandom_range(0, 10), $urandom_range(0, 40), 1'b0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_if.sv
hw/rtl/bbd_line_store.sv
hw/rtl/bbd_interp.sv
hw/rtl/bbd_out_buf.sv
hw/rtl/bilinear_bayer_demosaic_core.sv
bench/tb_top.sv
